>>> rtl/assert_macros.svh
// assertion helpers shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mfe_pkg;

  localparam int unsigned SlotW = 6;

  // slot layout of a full frame: lead pad, preamble, data, tail pad
  localparam logic [SlotW-1:0] SLOT_PREAMBLE = 6'd4;
  localparam logic [SlotW-1:0] SLOT_DATA     = 6'd20;
  localparam logic [SlotW-1:0] SLOT_TAIL     = 6'd36;
  localparam logic [SlotW-1:0] SLOT_END_BODY = 6'd35;
  localparam logic [SlotW-1:0] SLOT_END_TAIL = 6'd41;

  localparam logic [7:0] PREAMBLE_BYTE = 8'hFE;
  localparam logic [7:0] HOLD_RESET    = 8'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } mfe_in_t;

  typedef struct packed {
    logic       line_level;
    logic [7:0] hold_samples;
    logic       last_symbol;
  } mfe_out_t;

  typedef struct packed {
    logic line_level;
    logic last_symbol;
  } mfe_sym_t;

endpackage

`default_nettype wire

>>> rtl/mfe_symbol.sv
`timescale 1ns / 1ps
`default_nettype none

module mfe_symbol
  import mfe_pkg::*;
(
  input  mfe_in_t          item_i,
  input  logic [SlotW-1:0] slot_i,
  output mfe_sym_t         sym_o
);

  logic [SlotW-1:0] offset;
  logic [7:0]       byte_sel;
  logic             is_pad;
  logic [2:0]       bit_idx;
  logic             bit_val;
  logic [SlotW-1:0] end_slot;

  always_comb begin
    offset   = '0;
    byte_sel = item_i.data_byte;
    is_pad   = 1'b0;
    priority if (slot_i < SLOT_PREAMBLE) begin
      is_pad = 1'b1;
    end else if (slot_i < SLOT_DATA) begin
      offset   = slot_i - SLOT_PREAMBLE;
      byte_sel = PREAMBLE_BYTE;
    end else if (slot_i < SLOT_TAIL) begin
      offset = slot_i - SLOT_DATA;
    end else begin
      is_pad = 1'b1;
    end
  end

  // msb first, two half-bit symbols per bit
  assign bit_idx = 3'd7 - offset[3:1];
  assign bit_val = byte_sel[bit_idx];

  // a one is low then high, a zero high then low
  assign sym_o.line_level = is_pad ? 1'b0 : (bit_val ~^ offset[0]);

  assign end_slot          = item_i.last_byte ? SLOT_END_TAIL : SLOT_END_BODY;
  assign sym_o.last_symbol = (slot_i == end_slot);

endmodule

`default_nettype wire

>>> rtl/mfe_item_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module mfe_item_stage
  import mfe_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  mfe_in_t          in_data_i,
  input  logic             sym_ready_i,
  input  logic             sym_last_i,
  output logic             sym_valid_o,
  output mfe_in_t          item_o,
  output logic [SlotW-1:0] slot_o
);

  logic             busy_q, busy_d;
  logic [SlotW-1:0] slot_q, slot_d;
  mfe_in_t          item_q, item_d;
  logic             advance;
  logic             accept;

  assign advance    = busy_q && sym_ready_i;
  // next item enters as the final symbol of this one moves on
  assign in_ready_o = !busy_q || (advance && sym_last_i);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    busy_d = busy_q;
    slot_d = slot_q;
    item_d = item_q;
    priority if (accept) begin
      busy_d = 1'b1;
      item_d = in_data_i;
      slot_d = in_data_i.first_byte ? '0 : SLOT_DATA;
    end else if (advance && sym_last_i) begin
      busy_d = 1'b0;
    end else if (advance) begin
      slot_d = slot_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    item_q <= item_d;
  end

  assign sym_valid_o = busy_q;
  assign item_o      = item_q;
  assign slot_o      = slot_q;

endmodule

`default_nettype wire

>>> rtl/mfe_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module mfe_out_stage
  import mfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       sym_valid_i,
  output logic       sym_ready_o,
  input  mfe_sym_t   sym_i,
  input  logic [7:0] hold_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output mfe_out_t   out_data_o
);

  logic     valid_q;
  mfe_out_t data_q, data_d;
  logic     load;

  assign sym_ready_o = !valid_q || out_ready_i;
  assign load        = sym_valid_i && sym_ready_o;

  always_comb begin
    data_d = data_q;
    if (load) begin
      data_d.line_level   = sym_i.line_level;
      data_d.hold_samples = hold_i;
      data_d.last_symbol  = sym_i.last_symbol;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (sym_ready_o) begin
      valid_q <= sym_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

`default_nettype wire

>>> rtl/manchester_frame_encoder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  direction  payload     transaction when
// in       input      mfe_in_t    in_valid_i && in_ready_o
// out      output     mfe_out_t   out_valid_o && out_ready_i
// cfg      input      8-bit hold  cfg_valid_i && cfg_ready_o (always ready)
//
// one half-bit symbol per cycle while the output is not stalled: 16 symbols per byte,
// 36 with first_byte, 22 with last_byte, 42 with both; the slot counter in the item stage sets it
// the next byte is taken in the cycle the final symbol of the current one
// enters the output register, so frames run with no gap
// an accepted byte is registered in the item stage; its first symbol goes out once the output register takes it
// reset clears the busy and valid flags and loads a hold of 3 samples
// a stalled output freezes the slot counter and, while a byte is in progress, the input stays not ready

module manchester_frame_encoder_core
  import mfe_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  mfe_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output mfe_out_t out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i
);

  logic [7:0]       hold_q;
  logic             sym_valid;
  logic             sym_ready;
  mfe_in_t          item;
  logic [SlotW-1:0] slot;
  mfe_sym_t         sym;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= HOLD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      hold_q <= cfg_data_i;
    end
  end

  mfe_item_stage u_item (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .sym_ready_i (sym_ready),
    .sym_last_i  (sym.last_symbol),
    .sym_valid_o (sym_valid),
    .item_o      (item),
    .slot_o      (slot)
  );

  mfe_symbol u_symbol (
    .item_i (item),
    .slot_i (slot),
    .sym_o  (sym)
  );

  mfe_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sym_valid_i (sym_valid),
    .sym_ready_o (sym_ready),
    .sym_i       (sym),
    .hold_i      (hold_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> rtl/mfe_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mfe_checker
  import mfe_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input mfe_out_t   out_data_o,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o,
  input logic [7:0] cfg_data_i
);

  logic [7:0] hold_q;
  logic       out_stall;
  logic       in_xfer;

  assign out_stall = out_valid_o && !out_ready_i;
  assign in_xfer   = in_valid_i && in_ready_o;

  // shadow of the hold register as seen on the config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= HOLD_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      hold_q <= cfg_data_i;
    end
  end

  `ASSERT_NEXT(a_out_valid_holds, clk_i, rst_ni, out_stall, out_valid_o, "output valid dropped")
  `ASSERT_NEXT(a_out_data_holds, clk_i, rst_ni, out_stall, $stable(out_data_o), "payload changed")
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_xfer, !in_ready_o, "input ready too early")
  `ASSERT_SAME(a_hold_matches_cfg, clk_i, rst_ni, out_valid_o, out_data_o.hold_samples == hold_q, "hold mismatch")

endmodule

bind manchester_frame_encoder_core mfe_checker u_mfe_checker (.*);

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import mfe_pkg::*;

  localparam int LeadPadSymbols = 4;
  localparam int TailPadSymbols = 6;
  localparam int IdlePercent    = 37;
  localparam int CycleLimit     = 600000;
  localparam int ReportLimit    = 10;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid;
  logic       in_ready;
  mfe_in_t    in_data;
  logic       out_valid;
  logic       out_ready;
  mfe_out_t   out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;

  // encoder model state and expected line symbols
  logic [7:0] hold_setting;
  mfe_out_t   pending_symbols[$];

  bit idle_on;
  int cycle_count;
  int mismatch_count;
  int bytes_sent;
  int messages_sent;
  int symbols_seen;
  int hold_writes;

  manchester_frame_encoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic void push_symbol(input logic level);
    mfe_out_t sym;
    sym.line_level   = level;
    sym.hold_samples = hold_setting;
    sym.last_symbol  = 1'b0;
    pending_symbols.push_back(sym);
  endfunction

  // msb first; a one is low then high, a zero is high then low
  function automatic void push_manchester_byte(input logic [7:0] value);
    for (int i = 7; i >= 0; i--) begin
      push_symbol(~value[i]);
      push_symbol(value[i]);
    end
  endfunction

  function automatic void encode_frame_symbols(input mfe_in_t item);
    mfe_out_t tail;
    if (item.first_byte) begin
      repeat (LeadPadSymbols) push_symbol(1'b0);
      push_manchester_byte(PREAMBLE_BYTE);
    end
    push_manchester_byte(item.data_byte);
    if (item.last_byte) begin
      repeat (TailPadSymbols) push_symbol(1'b0);
    end
    tail = pending_symbols.pop_back();
    tail.last_symbol = 1'b1;
    pending_symbols.push_back(tail);
  endfunction

  function automatic void check_symbol(input mfe_out_t got);
    mfe_out_t want;
    symbols_seen++;
    if (pending_symbols.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= ReportLimit) begin
        $display("%0d: unexpected symbol level=%0b hold=%0d last=%0b", cycle_count,
                 got.line_level, got.hold_samples, got.last_symbol);
      end
      return;
    end
    want = pending_symbols.pop_front();
    if (got.line_level !== want.line_level || got.hold_samples !== want.hold_samples ||
        got.last_symbol !== want.last_symbol) begin
      mismatch_count++;
      if (mismatch_count <= ReportLimit) begin
        $display("%0d: symbol %0d expected level=%0b hold=%0d last=%0b,",
                 cycle_count, symbols_seen, want.line_level, want.hold_samples,
                 want.last_symbol);
        $display("    got level=%0b hold=%0d last=%0b",
                 got.line_level, got.hold_samples, got.last_symbol);
      end
    end
  endfunction

  // watches all three channels at each edge, in a fixed order
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (cfg_valid && cfg_ready) hold_setting = cfg_data;
        if (in_valid && in_ready) encode_frame_symbols(in_data);
        if (out_valid && out_ready) check_symbol(out_data);
      end
      out_ready <= !idle_on || ($urandom_range(0, 99) >= IdlePercent);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d symbols still expected", cycle_count,
             pending_symbols.size());
    $display("tb failed");
    $finish;
  end

  // leaves in_valid high after the transaction; the next call lowers it if it idles
  task automatic send_byte(input logic [7:0] value, input logic first, input logic last);
    mfe_in_t item;
    item.data_byte  = value;
    item.first_byte = first;
    item.last_byte  = last;
    if (idle_on && $urandom_range(0, 99) < IdlePercent) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < IdlePercent);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (!in_ready);
    bytes_sent++;
    if (first) messages_sent++;
  endtask

  task automatic wait_line_idle();
    in_valid <= 1'b0;
    // let the monitor queue a transaction taken at this edge before the check
    @(posedge clk_i);
    while (pending_symbols.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_hold(input logic [7:0] value);
    wait_line_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    hold_writes++;
  endtask

  task automatic send_message(input int len, input bit broken);
    logic first;
    logic last;
    for (int k = 0; k < len; k++) begin
      first = broken ? logic'($urandom_range(0, 1)) : logic'(k == 0);
      last  = broken ? logic'($urandom_range(0, 1)) : logic'(k == len - 1);
      send_byte(8'($urandom_range(0, 255)), first, last);
    end
  endtask

  // hold of 3 samples straight out of reset
  task automatic test_reset_hold();
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hA5, 1'b0, 1'b1);
  endtask

  task automatic test_flag_combinations();
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(8'h55, 1'b0, 1'b1);
    send_byte(8'hAA, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b1);
    send_byte(8'h00, 1'b1, 1'b1);
    send_byte(8'h7F, 1'b0, 1'b1);
    send_byte(8'hFE, 1'b1, 1'b0);
  endtask

  // holds of 0, 255 and 1 pass through unchanged
  task automatic test_hold_extremes();
    write_hold(8'd0);
    send_byte(8'h3C, 1'b1, 1'b1);
    send_byte(8'hC3, 1'b0, 1'b0);
    write_hold(8'd255);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    write_hold(8'd1);
    send_byte(8'h96, 1'b1, 1'b1);
    send_byte(8'h69, 1'b0, 1'b0);
  endtask

  task automatic test_drain_pause();
    send_byte(8'h12, 1'b1, 1'b0);
    send_byte(8'h34, 1'b0, 1'b0);
    wait_line_idle();
    send_byte(8'h56, 1'b0, 1'b0);
    send_byte(8'h78, 1'b0, 1'b1);
  endtask

  task automatic test_random_frames();
    logic [7:0] holds [5];
    int         target;
    int         len;
    holds[0] = 8'($urandom_range(2, 254));
    holds[1] = 8'd1;
    holds[2] = 8'd255;
    holds[3] = 8'd0;
    holds[4] = 8'($urandom_range(1, 255));
    for (int p = 0; p < 5; p++) begin
      write_hold(holds[p]);
      // one phase at full rate on both sides
      idle_on = (p != 1);
      target  = bytes_sent + 70;
      while (bytes_sent < target) begin
        len = $urandom_range(1, 6);
        send_message(len, $urandom_range(0, 99) < 15);
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_ni         <= 1'b0;
    in_valid       <= 1'b0;
    in_data        <= '0;
    cfg_valid      <= 1'b0;
    cfg_data       <= '0;
    hold_setting   = HOLD_RESET;
    idle_on        = 1'b1;
    mismatch_count = 0;
    bytes_sent     = 0;
    messages_sent  = 0;
    symbols_seen   = 0;
    hold_writes    = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_hold();
    test_flag_combinations();
    test_hold_extremes();
    test_drain_pause();
    test_random_frames();

    wait_line_idle();
    repeat (8) @(posedge clk_i);
    $display("encoded %0d bytes (%0d message starts) into %0d line symbols",
             bytes_sent, messages_sent, symbols_seen);
    $display("hold setting written %0d times incl. 0, 1 and 255; %0d mismatches",
             hold_writes, mismatch_count);
    if (mismatch_count == 0 && pending_symbols.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/mfe_pkg.sv
rtl/mfe_symbol.sv
rtl/mfe_item_stage.sv
rtl/mfe_out_stage.sv
rtl/manchester_frame_encoder_core.sv
rtl/mfe_checker.sv
sim/tb.sv
